// File: src/tfm_pkg.sv
// ----------------------------------------------------------------------------
// Tenengrad focus measure package
// Shared widths, register indexes and the per-pixel control struct.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tfm_pkg;

  // Field widths
  localparam int PIX_W  = 8;
  localparam int CFG_W  = 12;
  localparam int SUM_W  = 44;
  localparam int MEAN_W = 21;

  // Sobel gradient, square and per-pixel energy widths
  localparam int GRAD_W = 11;
  localparam int SQ_W   = 20;
  localparam int E_W    = 21;

  // Frame size limits and reset values
  localparam int MIN_SIZE       = 3;
  localparam int WIDTH_RESET    = 640;
  localparam int HEIGHT_RESET   = 480;

  // Divider iteration counter width
  localparam int DIV_CNT_W = 6;

  // Output stream packing: mean, then sum, padded to bytes
  localparam int OUT_W     = MEAN_W + SUM_W;
  localparam int OUT_BYTES = (OUT_W + 7) / 8;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  // Control that travels with one pixel down the pipeline
  typedef struct packed {
    logic valid;
    logic interior;
    logic last;
  } pix_ctrl_t;

endpackage

// File: src/tfm_line_buffer.sv
// ----------------------------------------------------------------------------
// Line buffer memory
// Holds the two previous rows, one entry per column: {row two above, row above}.
// Synchronous (registered) read, one write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tfm_line_buffer #(
  parameter int DEPTH = 2048
) (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [$clog2(DEPTH)-1:0]      rd_addr,
  output logic [2*tfm_pkg::PIX_W-1:0]   rd_data,
  input  logic                          wr_en,
  input  logic [$clog2(DEPTH)-1:0]      wr_addr,
  input  logic [2*tfm_pkg::PIX_W-1:0]   wr_data
);

  logic [2*tfm_pkg::PIX_W-1:0] mem [DEPTH];

  // Read the column taps
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Write back the shifted column
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

// File: src/tfm_gradient.sv
// ----------------------------------------------------------------------------
// Sobel gradient energy accumulator
// Keeps the 3x3 window, forms Sx and Sy, squares them and adds the energy
// to a saturating sum. Hands the sum to the divider on a frame's last pixel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tfm_gradient (
  input  logic                          clk,
  input  logic                          rst,
  input  tfm_pkg::pix_ctrl_t            ctrl,
  input  logic [tfm_pkg::PIX_W-1:0]     pixel,
  input  logic [2*tfm_pkg::PIX_W-1:0]   taps,
  output logic                          div_start,
  output logic [tfm_pkg::SUM_W-1:0]     div_sum,
  output logic                          last_pending
);

  localparam int PW = tfm_pkg::PIX_W;
  localparam int GW = tfm_pkg::GRAD_W;
  localparam int SW = tfm_pkg::SUM_W;

  logic [PW-1:0] tap_t, tap_m;
  logic [PW-1:0] tl, ml, bl, tc, mc, bc;

  logic signed [GW-1:0] ts, ms, bs, tls, mls, bls, tcs, bcs;
  logic signed [GW-1:0] sx_next, sy_next;
  logic signed [GW-1:0] sx, sy;
  tfm_pkg::pix_ctrl_t   b_ctrl, c_ctrl;

  logic signed [2*GW-1:0]      px, py;
  logic [tfm_pkg::SQ_W-1:0]    sqx, sqy;
  logic [tfm_pkg::E_W-1:0]     energy;
  logic [SW:0]                 acc_wide;
  logic [SW-1:0]               acc, acc_sum;

  assign tap_t = taps[2*PW-1:PW];
  assign tap_m = taps[PW-1:0];

  // Form the Sobel gradients around the center one row up, one column left
  always_comb begin
    ts  = GW'(tap_t);
    ms  = GW'(tap_m);
    bs  = GW'(pixel);
    tls = GW'(tl);
    mls = GW'(ml);
    bls = GW'(bl);
    tcs = GW'(tc);
    bcs = GW'(bc);
    sx_next = (ts - tls) + ((ms - mls) <<< 1) + (bs - bls);
    sy_next = (tls - bls) + ((tcs - bcs) <<< 1) + (ts - bs);
  end

  // Shift the window and register the gradients
  always_ff @(posedge clk) begin
    if (rst) begin
      tl <= '0;
      ml <= '0;
      bl <= '0;
      tc <= '0;
      mc <= '0;
      bc <= '0;
      b_ctrl <= '0;
    end else begin
      b_ctrl <= ctrl;
      if (ctrl.valid) begin
        tl <= tc;
        ml <= mc;
        bl <= bc;
        tc <= tap_t;
        mc <= tap_m;
        bc <= pixel;
        sx <= sx_next;
        sy <= sy_next;
      end
    end
  end

  // Square the gradients
  assign px = sx * sx;
  assign py = sy * sy;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_ctrl <= '0;
    end else begin
      c_ctrl <= b_ctrl;
      if (b_ctrl.valid) begin
        sqx <= px[tfm_pkg::SQ_W-1:0];
        sqy <= py[tfm_pkg::SQ_W-1:0];
      end
    end
  end

  // Add the energy of interior pixels with saturation at the top of the sum
  always_comb begin
    energy   = tfm_pkg::E_W'(sqx) + tfm_pkg::E_W'(sqy);
    acc_wide = (SW + 1)'(acc) + (SW + 1)'(energy);
    if (c_ctrl.interior) begin
      acc_sum = acc_wide[SW] ? {SW{1'b1}} : acc_wide[SW-1:0];
    end else begin
      acc_sum = acc;
    end
  end

  // Hold the sum, clear it after the frame's last pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (c_ctrl.valid) begin
      acc <= c_ctrl.last ? '0 : acc_sum;
    end
  end

  assign div_start    = c_ctrl.valid && c_ctrl.last;
  assign div_sum      = acc_sum;
  assign last_pending = (b_ctrl.valid && b_ctrl.last) || (c_ctrl.valid && c_ctrl.last);

endmodule

// File: src/tfm_divider.sv
// ----------------------------------------------------------------------------
// Frame mean divider
// Restoring divider, one quotient bit per cycle. Saturates the quotient to
// the mean width and holds the result until the output stage takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tfm_divider #(
  parameter int DEN_W = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [tfm_pkg::SUM_W-1:0]     dividend,
  input  logic [DEN_W-1:0]              divisor,
  output logic                          busy,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic [tfm_pkg::MEAN_W-1:0]    res_mean,
  output logic [tfm_pkg::SUM_W-1:0]     res_sum
);

  localparam int SW = tfm_pkg::SUM_W;
  localparam int MW = tfm_pkg::MEAN_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } div_state_t;

  div_state_t                    state;
  logic [DEN_W-1:0]              den;
  logic [DEN_W-1:0]              rem;
  logic [SW-1:0]                 quo;
  logic [tfm_pkg::DIV_CNT_W-1:0] cnt;
  logic [DEN_W:0]                trial, shifted;
  logic                          fits;

  // Try one subtraction of the divisor
  always_comb begin
    shifted = {rem, quo[SW-1]};
    trial   = shifted - {1'b0, den};
    fits    = !trial[DEN_W];
  end

  // Sequence the iterations and hold the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            den     <= divisor;
            quo     <= dividend;
            res_sum <= dividend;
            rem     <= '0;
            cnt     <= '0;
            state   <= ST_RUN;
          end
        end
        ST_RUN: begin
          rem <= fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
          quo <= {quo[SW-2:0], fits};
          cnt <= cnt + 1'b1;
          if (cnt == tfm_pkg::DIV_CNT_W'(SW - 1)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign busy      = (state != ST_IDLE);
  assign res_valid = (state == ST_DONE);
  assign res_mean  = (quo[SW-1:MW] != '0) ? {MW{1'b1}} : quo[MW-1:0];

endmodule

// File: src/tenengrad_focus_measure_top.sv
// ----------------------------------------------------------------------------
// Tenengrad focus measure
// Pixels of an 8-bit grayscale frame enter on the s_ stream in raster order,
// one transfer per pixel; the frame size comes from the cfg write port
// (index 0: width, index 1: height, clamped to 3..MAX_*).
// The block takes one pixel per cycle unless s_tready holds it off: the line
// buffer is read in the transfer cycle and written back in the next, at a
// different column than the following read. Gradient, square and accumulate
// follow in a three-stage pipeline behind it.
// On a frame's last pixel the sum goes to a restoring divider that produces
// one quotient bit per cycle; the result passes through the output register
// to the m_ stream as {sum, mean}.
// s_tready drops only for a frame's last pixel while the previous frame's
// last pixel is still in the pipeline, in division or held as a result; a
// stalled m_ side fills the output register and then the divider, so it
// blocks input only at the end of the second frame after the held result.
// Reset clears the counters, window, sum and output; the line buffer needs
// no clearing pass, its entries are written before they are read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tenengrad_focus_measure_top #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                               clk,
  input  logic                               rst,
  // Pixel stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [tfm_pkg::PIX_W-1:0]          s_tdata,  // [7:0] pixel
  // Result stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [8*tfm_pkg::OUT_BYTES-1:0]    m_tdata,  // [20:0] mean_energy, [64:21] energy_sum
  // Configuration writes
  input  logic                               cfg_wr_en,
  input  logic [tfm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tfm_pkg::CFG_W-1:0]          cfg_data
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int WSW_A = $clog2(MAX_WIDTH + 1);
  localparam int HSW_A = $clog2(MAX_HEIGHT + 1);
  localparam int WSW   = (WSW_A > tfm_pkg::CFG_W) ? WSW_A : tfm_pkg::CFG_W;
  localparam int HSW   = (HSW_A > tfm_pkg::CFG_W) ? HSW_A : tfm_pkg::CFG_W;
  localparam int DEN_W = WSW + HSW;
  localparam int PW    = tfm_pkg::PIX_W;

  logic [tfm_pkg::CFG_W-1:0] frame_width, frame_height;
  logic [WSW-1:0]            fw_ext, w_use, col_inc;
  logic [HSW-1:0]            fh_ext, h_use, row_inc;
  logic [CW-1:0]             col;
  logic [RW-1:0]             row;
  logic                      row_end, last_now, accept;

  tfm_pkg::pix_ctrl_t        a_ctrl;
  logic [PW-1:0]             a_pix;
  logic [CW-1:0]             a_col;
  logic [2*PW-1:0]           taps;
  logic [DEN_W-1:0]          den;

  logic                      div_start, grad_pending, div_busy;
  logic [tfm_pkg::SUM_W-1:0] div_sum;
  logic                      res_valid, res_ready;
  logic [tfm_pkg::MEAN_W-1:0] res_mean;
  logic [tfm_pkg::SUM_W-1:0] res_sum;

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= tfm_pkg::CFG_W'(tfm_pkg::WIDTH_RESET);
      frame_height <= tfm_pkg::CFG_W'(tfm_pkg::HEIGHT_RESET);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        tfm_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        tfm_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the frame size and find the row and frame ends
  always_comb begin
    fw_ext = WSW'(frame_width);
    fh_ext = HSW'(frame_height);
    if (fw_ext < WSW'(tfm_pkg::MIN_SIZE)) begin
      w_use = WSW'(tfm_pkg::MIN_SIZE);
    end else if (fw_ext > WSW'(MAX_WIDTH)) begin
      w_use = WSW'(MAX_WIDTH);
    end else begin
      w_use = fw_ext;
    end
    if (fh_ext < HSW'(tfm_pkg::MIN_SIZE)) begin
      h_use = HSW'(tfm_pkg::MIN_SIZE);
    end else if (fh_ext > HSW'(MAX_HEIGHT)) begin
      h_use = HSW'(MAX_HEIGHT);
    end else begin
      h_use = fh_ext;
    end
    col_inc  = WSW'(col) + WSW'(1);
    row_inc  = HSW'(row) + HSW'(1);
    row_end  = (col_inc >= w_use);
    last_now = row_end && (row_inc >= h_use);
  end

  // Hold off a frame end until the divider is free
  assign s_tready = !(last_now && (div_busy || grad_pending || (a_ctrl.valid && a_ctrl.last)));
  assign accept   = s_tvalid && s_tready;

  // Advance the raster position
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (row_end) begin
        col <= '0;
        row <= last_now ? '0 : row_inc[RW-1:0];
      end else begin
        col <= col_inc[CW-1:0];
      end
    end
  end

  // Register the accepted pixel for the tap stage
  always_ff @(posedge clk) begin
    if (rst) begin
      a_ctrl <= '0;
    end else begin
      a_ctrl.valid    <= accept;
      a_ctrl.interior <= (col >= CW'(2)) && (row >= RW'(2));
      a_ctrl.last     <= last_now;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_pix <= s_tdata;
      a_col <= col;
    end
  end

  // Latch the interior pixel count of the ending frame
  always_ff @(posedge clk) begin
    if (accept && last_now) begin
      den <= DEN_W'(w_use - WSW'(2)) * DEN_W'(h_use - HSW'(2));
    end
  end

  tfm_line_buffer #(
    .DEPTH (MAX_WIDTH)
  ) u_line_buffer (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col),
    .rd_data (taps),
    .wr_en   (a_ctrl.valid),
    .wr_addr (a_col),
    .wr_data ({taps[PW-1:0], a_pix})
  );

  tfm_gradient u_gradient (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (a_ctrl),
    .pixel        (a_pix),
    .taps         (taps),
    .div_start    (div_start),
    .div_sum      (div_sum),
    .last_pending (grad_pending)
  );

  tfm_divider #(
    .DEN_W (DEN_W)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_sum),
    .divisor   (den),
    .busy      (div_busy),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_mean  (res_mean),
    .res_sum   (res_sum)
  );

  // Output register between the divider and the result stream
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_tdata <= (8 * tfm_pkg::OUT_BYTES)'({res_sum, res_mean});
    end
  end

  // A new division never starts over a running or held one
  assert property (@(posedge clk) disable iff (rst) div_start |-> !div_busy)
    else $error("divider started while busy");

  // The raster position returns to the origin after a frame's last pixel
  assert property (@(posedge clk) disable iff (rst)
    (accept && last_now) |=> (col == '0 && row == '0))
    else $error("counters not cleared at frame end");

  // A result appears only from a finished division
  assert property (@(posedge clk) disable iff (rst) $rose(m_tvalid) |-> $past(res_valid))
    else $error("result without a finished division");

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// Tenengrad focus measure testbench
// Streams grayscale frames of many sizes into the block, including sizes
// clamped up to the minimum and resizes in the middle of a frame.
// A behavioral predictor tracks line buffers, window and gradient sum per
// accepted pixel, and every frame result is checked field by field.
// Both stream sides idle at random, and the result side holds off once for
// a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int PIX_W        = tfm_pkg::PIX_W;
  localparam int CFG_W        = tfm_pkg::CFG_W;
  localparam int CFG_IDX_W    = tfm_pkg::CFG_IDX_W;
  localparam int SUM_W        = tfm_pkg::SUM_W;
  localparam int MEAN_W       = tfm_pkg::MEAN_W;
  localparam int OUT_BYTES    = tfm_pkg::OUT_BYTES;
  localparam int MIN_SIZE     = tfm_pkg::MIN_SIZE;
  localparam int WIDTH_RESET  = tfm_pkg::WIDTH_RESET;
  localparam int HEIGHT_RESET = tfm_pkg::HEIGHT_RESET;

  localparam int MAX_W        = 2048;
  localparam int MAX_H        = 2048;
  localparam int DRAIN_CYCLES = 80;
  localparam int HOLD_CYCLES  = 600;
  localparam int END_WAIT     = 5000;
  localparam int CALM_ITEMS   = 120;
  localparam int ITEM_TARGET  = 850;
  localparam int MIN_FRAMES   = 40;
  localparam int MAX_PRINTS   = 40;
  localparam longint TIMEOUT_NS = 64'd8_000_000;

  localparam logic [63:0] SUM_LIMIT  = (64'd1 << SUM_W) - 1;
  localparam logic [63:0] MEAN_LIMIT = (64'd1 << MEAN_W) - 1;

  typedef enum {STIM_PIXEL, STIM_CFG, STIM_HOLD} stim_kind_t;
  typedef enum {TEX_NOISE, TEX_BINARY, TEX_FLAT} texture_t;

  typedef struct {
    stim_kind_t             kind;
    logic [PIX_W-1:0]       pixel;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_W-1:0]       value;
  } stim_item_t;

  typedef struct {
    logic [MEAN_W-1:0] mean;
    logic [SUM_W-1:0]  sum;
  } focus_result_t;

  // DUT ports
  logic                        clk;
  logic                        rst       = 1'b1;
  logic                        s_tvalid  = 1'b0;
  logic                        s_tready;
  logic [PIX_W-1:0]            s_tdata   = '0;  // [7:0] pixel
  logic                        m_tvalid;
  logic                        m_tready  = 1'b0;
  logic [8*OUT_BYTES-1:0]      m_tdata;         // [20:0] mean_energy, [64:21] energy_sum
  logic                        cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [CFG_W-1:0]            cfg_data  = '0;

  // Stimulus and expected frame results
  stim_item_t    stim_q[$];
  focus_result_t pending_results[$];

  // Predictor state
  logic [PIX_W-1:0] row1_buf [MAX_W];
  logic [PIX_W-1:0] row2_buf [MAX_W];
  int               win [6];
  int               col_pos = 0;
  int               row_pos = 0;
  logic [63:0]      energy_acc = '0;
  logic [CFG_W-1:0] width_reg  = WIDTH_RESET;
  logic [CFG_W-1:0] height_reg = HEIGHT_RESET;

  // Generator bookkeeping
  int gen_w_raw  = WIDTH_RESET;
  int gen_h_raw  = HEIGHT_RESET;
  int col_reach  = 0;
  int px_count   = 0;
  int frames_gen = 0;
  int cfg_writes = 0;

  // Flow control state
  logic hold_req = 1'b0;
  logic calm     = 1'b0;
  int   hold_left  = 0;
  int   send_gap   = 0;
  int   send_quiet = 0;
  int   settle_cnt = DRAIN_CYCLES;
  int   rx_gap     = 0;
  int   rx_quiet   = 0;

  int mismatches   = 0;
  int results_seen = 0;

  tenengrad_focus_measure_top #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("status: fail");
    $finish;
  end

  function automatic int clamp_dim(input int v, input int hi);
    if (v < MIN_SIZE) return MIN_SIZE;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    if (mismatches < MAX_PRINTS)
      $display("%0t ns  mismatch: %s got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Advance the gradient energy predictor by one accepted pixel
  function automatic void track_pixel(input logic [PIX_W-1:0] px);
    int            w, h, t, m, b, tl, ml, bl, tc, bc, sx, sy, e;
    logic [63:0]   div, q;
    focus_result_t res;
    w = clamp_dim(width_reg, MAX_W);
    h = clamp_dim(height_reg, MAX_H);
    b = px;
    t = 0;
    m = 0;
    if (col_pos < MAX_W) begin
      t = row2_buf[col_pos];
      m = row1_buf[col_pos];
      row2_buf[col_pos] = m[PIX_W-1:0];
      row1_buf[col_pos] = px;
    end
    tl = win[0];
    ml = win[1];
    bl = win[2];
    tc = win[3];
    bc = win[5];
    // interior pixels only: Sobel x and y around the center one row up, one column left
    if (col_pos >= 2 && row_pos >= 2) begin
      sx = -tl + t - 2 * ml + 2 * m - bl + b;
      sy = tl + 2 * tc + t - bl - 2 * bc - b;
      e  = sx * sx + sy * sy;
      if (energy_acc > SUM_LIMIT - 64'(e)) energy_acc = SUM_LIMIT;
      else energy_acc = energy_acc + 64'(e);
    end
    win[0] = win[3];
    win[1] = win[4];
    win[2] = win[5];
    win[3] = t;
    win[4] = m;
    win[5] = b;
    // row and frame wrap; a shrunk size ends the row or frame at once
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      if (row_pos + 1 >= h) begin
        div = 64'(w - 2) * 64'(h - 2);
        q   = energy_acc / div;
        if (q > MEAN_LIMIT) q = MEAN_LIMIT;
        res.mean = q[MEAN_W-1:0];
        res.sum  = energy_acc[SUM_W-1:0];
        pending_results.push_back(res);
        row_pos    = 0;
        energy_acc = '0;
      end else begin
        row_pos++;
      end
    end else begin
      col_pos++;
    end
  endfunction

  task automatic push_one(input stim_kind_t kind, input logic [PIX_W-1:0] px,
                          input logic [CFG_IDX_W-1:0] idx, input int value);
    stim_item_t it;
    it.kind  = kind;
    it.pixel = px;
    it.idx   = idx;
    it.value = value[CFG_W-1:0];
    stim_q.push_back(it);
  endtask

  task automatic push_cfg(input logic [CFG_IDX_W-1:0] idx, input int value);
    push_one(STIM_CFG, '0, idx, value);
    if (idx == tfm_pkg::REG_FRAME_WIDTH) gen_w_raw = value;
    else gen_h_raw = value;
    cfg_writes++;
  endtask

  task automatic push_pixels(input int n, input texture_t tex);
    logic [PIX_W-1:0] level;
    logic [PIX_W-1:0] px;
    level = $urandom_range(255, 0);
    for (int i = 0; i < n; i++) begin
      case (tex)
        TEX_NOISE:  px = $urandom_range(255, 0);
        TEX_BINARY: px = $urandom_range(1, 0) ? 8'hFF : 8'h00;
        default:    px = level;
      endcase
      push_one(STIM_PIXEL, px, '0, 0);
    end
    px_count += n;
  endtask

  // Queue one frame; optionally resize after a random point past the first row.
  // Resized width never exceeds the columns already visited, so every line
  // buffer entry that feeds a gradient has been written.
  task automatic push_frame(input int wraw, input int hraw, input texture_t tex,
                            input bit reshape);
    int w, h, r, c, w2, h2, rest, sel;
    if (wraw != gen_w_raw) push_cfg(tfm_pkg::REG_FRAME_WIDTH, wraw);
    if (hraw != gen_h_raw) push_cfg(tfm_pkg::REG_FRAME_HEIGHT, hraw);
    w = clamp_dim(wraw, MAX_W);
    h = clamp_dim(hraw, MAX_H);
    if (w > col_reach) col_reach = w;
    if (!reshape) begin
      push_pixels(w * h, tex);
    end else begin
      r = $urandom_range(h - 1, 1);
      c = $urandom_range(w - 1, 0);
      push_pixels(r * w + c, tex);
      sel = $urandom_range(2, 0);
      if (sel != 1)
        push_cfg(tfm_pkg::REG_FRAME_WIDTH, $urandom_range(col_reach < 10 ? col_reach : 10, 0));
      if (sel != 0) push_cfg(tfm_pkg::REG_FRAME_HEIGHT, $urandom_range(6, 0));
      w2   = clamp_dim(gen_w_raw, MAX_W);
      h2   = clamp_dim(gen_h_raw, MAX_H);
      rest = (w2 - c > 1) ? w2 - c : 1;
      if (r + 1 < h2) rest += w2 * (h2 - r - 1);
      push_pixels(rest, tex);
    end
    frames_gen++;
  endtask

  // Pixel and register driver; a register write waits until all frame results
  // are in and the pipeline has drained
  always @(posedge clk) begin : pixel_driver
    logic       nvalid;
    logic       nwr;
    logic       nhold;
    stim_item_t it;
    if (rst) begin
      s_tvalid  <= 1'b0;
      cfg_wr_en <= 1'b0;
      hold_req  <= 1'b0;
      calm      <= 1'b0;
    end else begin
      nvalid = s_tvalid;
      nwr    = 1'b0;
      nhold  = 1'b0;
      if (s_tvalid && s_tready) begin
        track_pixel(s_tdata);
        nvalid     = 1'b0;
        settle_cnt = DRAIN_CYCLES;
      end
      if (pending_results.size() != 0) settle_cnt = DRAIN_CYCLES;
      if (!nvalid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (stim_q.size() != 0) begin
          it = stim_q[0];
          case (it.kind)
            STIM_PIXEL: begin
              if (!calm && send_quiet == 0 && $urandom_range(9, 0) == 0) begin
                send_gap = $urandom_range(18, 0);
                if ($urandom_range(3, 0) == 0) send_quiet = $urandom_range(120, 20);
              end else begin
                if (send_quiet > 0) send_quiet--;
                void'(stim_q.pop_front());
                s_tdata <= it.pixel;
                nvalid = 1'b1;
              end
            end
            STIM_CFG: begin
              if (settle_cnt > 0) begin
                settle_cnt--;
              end else begin
                void'(stim_q.pop_front());
                cfg_index <= it.idx;
                cfg_data  <= it.value;
                nwr = 1'b1;
                if (it.idx == tfm_pkg::REG_FRAME_WIDTH) width_reg = it.value;
                else height_reg = it.value;
              end
            end
            default: begin
              void'(stim_q.pop_front());
              nhold = 1'b1;
            end
          endcase
        end
      end
      s_tvalid  <= nvalid;
      cfg_wr_en <= nwr;
      hold_req  <= nhold;
      calm      <= (stim_q.size() < CALM_ITEMS);
    end
  end

  // Long hold-off of the result side, counted here
  always @(posedge clk) begin
    if (rst) hold_left <= 0;
    else if (hold_req) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // Result monitor: compare each transfer against the oldest pending frame
  always @(posedge clk) begin : result_monitor
    focus_result_t want;
    logic          nready;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch("result with no frame pending, energy_sum",
                          m_tdata[MEAN_W +: SUM_W], 0);
        end else begin
          want = pending_results.pop_front();
          if (m_tdata[MEAN_W-1:0] !== want.mean)
            report_mismatch("mean_energy", m_tdata[MEAN_W-1:0], want.mean);
          if (m_tdata[MEAN_W +: SUM_W] !== want.sum)
            report_mismatch("energy_sum", m_tdata[MEAN_W +: SUM_W], want.sum);
        end
      end
      if (rx_gap > 0) begin
        rx_gap--;
        nready = 1'b0;
      end else if (!calm && rx_quiet == 0 && $urandom_range(5, 0) == 0) begin
        rx_gap = $urandom_range(18, 0);
        if ($urandom_range(3, 0) == 0) rx_quiet = $urandom_range(300, 50);
        nready = 1'b0;
      end else begin
        if (rx_quiet > 0) rx_quiet--;
        nready = 1'b1;
      end
      m_tready <= nready && (hold_left == 0);
    end
  end

  initial begin : main
    int       k, wr, hr;
    texture_t tex;

    // Directed: one 3x3 frame with strong edges, one clamped 3x3 flat frame
    push_cfg(tfm_pkg::REG_FRAME_WIDTH, 3);
    push_cfg(tfm_pkg::REG_FRAME_HEIGHT, 3);
    push_one(STIM_PIXEL, 8'h00, '0, 0);
    push_one(STIM_PIXEL, 8'hFF, '0, 0);
    push_one(STIM_PIXEL, 8'hFF, '0, 0);
    push_one(STIM_PIXEL, 8'h00, '0, 0);
    push_one(STIM_PIXEL, 8'h55, '0, 0);
    push_one(STIM_PIXEL, 8'hFF, '0, 0);
    push_one(STIM_PIXEL, 8'h00, '0, 0);
    push_one(STIM_PIXEL, 8'h00, '0, 0);
    push_one(STIM_PIXEL, 8'hFF, '0, 0);
    px_count   = 9;
    frames_gen = 1;
    col_reach  = 3;
    push_cfg(tfm_pkg::REG_FRAME_WIDTH, 1);
    push_cfg(tfm_pkg::REG_FRAME_HEIGHT, 2);
    for (k = 0; k < 9; k++) push_one(STIM_PIXEL, 8'hFF, '0, 0);
    px_count += 9;
    frames_gen++;

    // Random frames, and a burst of equal-size frames behind a long result-side hold-off
    for (k = 0; frames_gen < MIN_FRAMES || px_count < ITEM_TARGET; k++) begin
      tex = texture_t'($urandom_range(2, 0));
      if (k == 10) begin
        push_frame(4, 3, TEX_NOISE, 1'b0);
        push_one(STIM_HOLD, '0, '0, 0);
        repeat (8) push_frame(4, 3, texture_t'($urandom_range(2, 0)), 1'b0);
      end else begin
        wr = ($urandom_range(9, 0) == 0) ? $urandom_range(2, 0) : $urandom_range(8, 3);
        hr = ($urandom_range(9, 0) == 0) ? $urandom_range(2, 0) : $urandom_range(6, 3);
        push_frame(wr, hr, tex, $urandom_range(5, 0) == 0);
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Wait for the input side, then for the outstanding frame results
    while (stim_q.size() != 0 || s_tvalid) @(negedge clk);
    for (k = 0; k < END_WAIT && pending_results.size() != 0; k++) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (pending_results.size() != 0)
      report_mismatch("frame results never delivered", pending_results.size(), 0);

    $display("covered %0d frames, %0d pixels, %0d register writes, %0d results checked",
             frames_gen, px_count, cfg_writes, results_seen);
    $display("small frame sizes incl. clamped ones, mid-frame resizes, stalls on both sides");
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
